### src/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

  localparam int unsigned HdrLen = 5;
  localparam int unsigned TotalW = 17;
  localparam int unsigned LenW = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MagicBytes = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RECORD_TYPE     = 2'd0,
    REG_MAX_TOTAL_LEN   = 2'd1,
    REG_MIN_TOTAL_LEN   = 2'd2,
    REG_HANDSHAKE_MAGIC = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_BAD_TYPE = 2'd1,
    KIND_BAD_LEN  = 2'd2
  } kind_e;

  localparam logic [7:0]          RecordTypeRst = 8'h17;
  localparam logic [TotalW-1:0]   MaxTotalRst   = 17'd2048;
  localparam logic [TotalW-1:0]   MinTotalRst   = 17'd16;
  localparam logic [31:0]         MagicRst      = 32'hA55A5AA5;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic       handshake;
  } result_t;

endpackage

`default_nettype wire

### src/record_stream_deframer.sv
`default_nettype none

// Record deframer for a raw receive byte stream. It takes one byte per clock
// while input stall is low, strips the five-byte header (type, two ignored
// bytes, big-endian length), and returns each payload byte with a last mark,
// or one error request for a wrong type byte or an out-of-range record length.
// Each result is registered into a two-entry output buffer; input stall rises
// only when both entries are occupied, so with a free-running consumer the
// block sustains one byte per clock. Accepted header bytes and zero-length
// records produce no result. Configuration writes go through a plain write
// port and must be issued while the block is idle.
module record_stream_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    in_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         out_byte_o,
  output logic                               last_o,
  output logic                               handshake_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rsd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rsd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    buf_full;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  rsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rsd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_res)
  );

  assign kind_o      = out_res.kind;
  assign out_byte_o  = out_res.data;
  assign last_o      = out_res.last;
  assign handshake_o = out_res.handshake;

  a_hs_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handshake_o |-> last_o && kind_o == KIND_DATA)
    else $error("handshake flag outside a final payload byte");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> out_byte_o == 8'd0 && !last_o && !handshake_o)
    else $error("error result carries payload fields");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output buffer");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("output buffer did not free an entry after a pop");

endmodule

`default_nettype wire

### src/rsd_parser.sv
`default_nettype none

module rsd_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rsd_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                               res_valid_o,
  output rsd_pkg::result_t                   res_o
);
  import rsd_pkg::*;

  typedef enum logic [2:0] {
    HDR_TYPE   = 3'd0,
    HDR_SKIP1  = 3'd1,
    HDR_SKIP2  = 3'd2,
    HDR_LEN_HI = 3'd3,
    HDR_LEN_LO = 3'd4
  } hdr_e;

  logic [7:0]        record_type_q;
  logic [TotalW-1:0] max_total_q;
  logic [TotalW-1:0] min_total_q;
  logic [31:0]       magic_q;

  logic              in_payload_q, in_payload_d;
  hdr_e              hdr_q, hdr_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [LenW-1:0]   bytes_left_q, bytes_left_d;
  logic [3:0]        payload_pos_q, payload_pos_d;
  logic [31:0]       magic_acc_q, magic_acc_d;
  logic              first_done_q, first_done_d;

  logic [LenW-1:0]   len;
  logic [TotalW-1:0] total;

  assign len   = {len_hi_q, in_byte_i};
  assign total = TotalW'(len) + TotalW'(HdrLen);

  always_comb begin
    in_payload_d  = in_payload_q;
    hdr_d         = hdr_q;
    len_hi_d      = len_hi_q;
    bytes_left_d  = bytes_left_q;
    payload_pos_d = payload_pos_q;
    magic_acc_d   = magic_acc_q;
    first_done_d  = first_done_q;
    res_valid_o   = 1'b0;
    res_o         = '{kind: KIND_DATA, data: 8'd0, last: 1'b0, handshake: 1'b0};

    if (accept_i) begin
      if (in_payload_q) begin
        // fold the first eight payload bytes into the magic word
        if (payload_pos_q < 4'(MagicBytes)) begin
          magic_acc_d   = magic_acc_q ^ (32'(in_byte_i) << {payload_pos_q[1:0], 3'b000});
          payload_pos_d = payload_pos_q + 4'd1;
        end
        bytes_left_d = bytes_left_q - LenW'(1);
        res_valid_o  = 1'b1;
        res_o.data   = in_byte_i;
        if (bytes_left_d == '0) begin
          res_o.last      = 1'b1;
          res_o.handshake = !first_done_q && (magic_acc_d == magic_q);
          first_done_d    = 1'b1;
          in_payload_d    = 1'b0;
          hdr_d           = HDR_TYPE;
        end
      end else begin
        unique case (hdr_q)
          HDR_TYPE: begin
            if (in_byte_i != record_type_q) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_BAD_TYPE;
            end else begin
              hdr_d = HDR_SKIP1;
            end
          end
          HDR_SKIP1:  hdr_d = HDR_SKIP2;
          HDR_SKIP2:  hdr_d = HDR_LEN_HI;
          HDR_LEN_HI: begin
            len_hi_d = in_byte_i;
            hdr_d    = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            hdr_d = HDR_TYPE;
            if (total > max_total_q || total < min_total_q) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_BAD_LEN;
            end else begin
              payload_pos_d = 4'd0;
              magic_acc_d   = 32'd0;
              if (len == '0) begin
                first_done_d = 1'b1;
              end else begin
                bytes_left_d = len;
                in_payload_d = 1'b1;
              end
            end
          end
          default: hdr_d = HDR_TYPE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_type_q <= RecordTypeRst;
      max_total_q   <= MaxTotalRst;
      min_total_q   <= MinTotalRst;
      magic_q       <= MagicRst;
      in_payload_q  <= 1'b0;
      hdr_q         <= HDR_TYPE;
      len_hi_q      <= 8'd0;
      bytes_left_q  <= '0;
      payload_pos_q <= 4'd0;
      magic_acc_q   <= 32'd0;
      first_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_RECORD_TYPE:     record_type_q <= cfg_data_i[7:0];
          REG_MAX_TOTAL_LEN:   max_total_q   <= cfg_data_i[TotalW-1:0];
          REG_MIN_TOTAL_LEN:   min_total_q   <= cfg_data_i[TotalW-1:0];
          REG_HANDSHAKE_MAGIC: magic_q       <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      in_payload_q  <= in_payload_d;
      hdr_q         <= hdr_d;
      len_hi_q      <= len_hi_d;
      bytes_left_q  <= bytes_left_d;
      payload_pos_q <= payload_pos_d;
      magic_acc_q   <= magic_acc_d;
      first_done_q  <= first_done_d;
    end
  end

endmodule

`default_nettype wire

### src/rsd_skid.sv
`default_nettype none

module rsd_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  rsd_pkg::result_t      push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output rsd_pkg::result_t      data_o
);
  import rsd_pkg::*;

  logic [1:0] count_q;
  result_t    head_q;
  result_t    tail_q;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      priority case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    // head always holds the oldest request; tail is the overflow slot
    if (pop) begin
      if (count_q == 2'd2) begin
        head_q <= tail_q;
      end else if (push_i) begin
        head_q <= push_data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_q <= push_data_i;
      end else begin
        tail_q <= push_data_i;
      end
    end
  end

endmodule

`default_nettype wire

### verif/deframe_checker.sv
module deframe_checker
  import rsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [7:0]          in_byte_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          out_byte_i,
  input  logic                last_i,
  input  logic                handshake_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  logic [7:0]        type_reg;
  logic [TotalW-1:0] max_reg;
  logic [TotalW-1:0] min_reg;
  logic [31:0]       magic_reg;

  logic              in_payload;
  logic              first_done;
  logic [2:0]        header_pos;
  logic [7:0]        len_high;
  logic [LenW-1:0]   bytes_left;
  logic [3:0]        payload_pos;
  logic [31:0]       magic_acc;

  result_t           rec_out_q[$];
  int unsigned       mismatches;
  int unsigned       results_seen;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Advance the deframer by one stream byte and queue any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    result_t           res;
    logic [TotalW-1:0] total;
    res.kind      = KIND_DATA;
    res.data      = b;
    res.last      = 1'b0;
    res.handshake = 1'b0;
    if (in_payload) begin
      if (payload_pos < MagicBytes) begin
        magic_acc   = magic_acc ^ ({24'd0, b} << {payload_pos[1:0], 3'b000});
        payload_pos = payload_pos + 4'd1;
      end
      bytes_left = bytes_left - LenW'(1);
      if (bytes_left == '0) begin
        res.last      = 1'b1;
        res.handshake = !first_done && (magic_acc == magic_reg);
        first_done    = 1'b1;
        in_payload    = 1'b0;
        header_pos    = 3'd0;
      end
      rec_out_q.push_back(res);
    end else begin
      res.data = 8'd0;
      case (header_pos)
        3'd0: begin
          // stay on the type byte until one matches
          if (b != type_reg) begin
            res.kind = KIND_BAD_TYPE;
            rec_out_q.push_back(res);
          end else begin
            header_pos = 3'd1;
          end
        end
        3'd1, 3'd2: header_pos = header_pos + 3'd1;
        3'd3: begin
          len_high   = b;
          header_pos = 3'd4;
        end
        default: begin
          total      = {1'b0, len_high, b} + TotalW'(HdrLen);
          header_pos = 3'd0;
          if (total > max_reg || total < min_reg) begin
            res.kind = KIND_BAD_LEN;
            rec_out_q.push_back(res);
          end else begin
            payload_pos = '0;
            magic_acc   = '0;
            if ({len_high, b} == 16'd0) begin
              first_done = 1'b1;
            end else begin
              bytes_left = {len_high, b};
              in_payload = 1'b1;
            end
          end
        end
      endcase
    end
  endtask

  task automatic compare_result();
    result_t want;
    results_seen++;
    if (rec_out_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with none expected (kind %0d byte %02h)",
                                results_seen, kind_i, out_byte_i));
    end else begin
      want = rec_out_q.pop_front();
      if (kind_i !== want.kind)
        report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                  results_seen, kind_i, want.kind));
      if (out_byte_i !== want.data)
        report_mismatch($sformatf("result %0d byte %02h, want %02h",
                                  results_seen, out_byte_i, want.data));
      if (last_i !== want.last)
        report_mismatch($sformatf("result %0d last %b, want %b",
                                  results_seen, last_i, want.last));
      if (handshake_i !== want.handshake)
        report_mismatch($sformatf("result %0d handshake %b, want %b",
                                  results_seen, handshake_i, want.handshake));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_reg     = RecordTypeRst;
      max_reg      = MaxTotalRst;
      min_reg      = MinTotalRst;
      magic_reg    = MagicRst;
      in_payload   = 1'b0;
      first_done   = 1'b0;
      header_pos   = '0;
      len_high     = '0;
      bytes_left   = '0;
      payload_pos  = '0;
      magic_acc    = '0;
      results_seen = 0;
      mismatches   = 0;
      rec_out_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // drain before predicting: a new request never produces a result in its own cycle
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) deframe_byte(in_byte_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RECORD_TYPE:     type_reg  = cfg_data_i[7:0];
          REG_MAX_TOTAL_LEN:   max_reg   = cfg_data_i[TotalW-1:0];
          REG_MIN_TOTAL_LEN:   min_reg   = cfg_data_i[TotalW-1:0];
          REG_HANDSHAKE_MAGIC: magic_reg = cfg_data_i[31:0];
          default: ;
        endcase
      end
      pending_o    <= rec_out_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

### verif/tb.sv
module tb;
  import rsd_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_byte;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          kind;
  logic [7:0]          out_byte;
  logic                last;
  logic                handshake;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         pending_cnt;
  int unsigned         mismatch_cnt;

  // stimulus-side copy of the registers, used only to shape the byte stream
  logic [7:0]          cur_type;
  int unsigned         cur_max;
  int unsigned         cur_min;
  logic [31:0]         cur_magic;

  bit                  idle_off;
  bit                  hold_req;
  int unsigned         bytes_sent;
  int unsigned         cycle_cnt;

  record_stream_deframer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .out_byte_o  (out_byte),
    .last_o      (last),
    .handshake_o (handshake),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  deframe_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .out_byte_i   (out_byte),
    .last_i       (last),
    .handshake_i  (handshake),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_cnt),
    .mismatches_o (mismatch_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall per request, one long hold-off when asked.
  initial begin : receiver
    int unsigned wait_cycles;
    forever begin
      wait_cycles = hold_req ? HoldCycles : (idle_off ? 0 : $urandom_range(0, 8));
      hold_req = 1'b0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] typ, input logic [15:0] len);
    push_byte(typ);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endtask

  // With hit set, words 0 and 1 are built to XOR to the current magic.
  task automatic send_payload(input int unsigned len, input bit hit);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [7:0]  b;
    int unsigned i;
    w0 = $urandom;
    w1 = w0 ^ cur_magic;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (hit && i < 4) b = w0[8*i +: 8];
      else if (hit && i < 8) b = w1[8*(i-4) +: 8];
      push_byte(b);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RECORD_TYPE:     cur_type  = val[7:0];
      REG_MAX_TOTAL_LEN:   cur_max   = val[TotalW-1:0];
      REG_MIN_TOTAL_LEN:   cur_min   = val[TotalW-1:0];
      REG_HANDSHAKE_MAGIC: cur_magic = val;
      default: ;
    endcase
  endtask

  // Drop valid and wait until every expected result is out, plus pipeline slack.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned lo;
    int unsigned hi;
    int unsigned top;
    int unsigned len;
    int unsigned pick;
    bit          fits;
    logic [7:0]  b;
    start = bytes_sent;
    lo    = cur_min - HdrLen;
    fits  = cur_max >= cur_min;
    hi    = fits ? cur_max - HdrLen : lo;
    if (hi > lo + 40) hi = lo + 40;
    while (bytes_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) idle_off = !idle_off;
      if (pick < 65 && fits) begin
        len = $urandom_range(lo, hi);
        send_header(cur_type, 16'(len));
        send_payload(len, $urandom_range(0, 7) == 0);
      end else if (pick < 80) begin
        if (cur_max - 4 <= 65535 && $urandom_range(0, 1) == 1) begin
          top = ($urandom_range(0, 3) == 0 || cur_max + 30 > 65535) ? 65535 : cur_max + 30;
          len = $urandom_range(cur_max - 4, top);
        end else begin
          len = $urandom_range(0, lo - 1);
        end
        send_header(cur_type, 16'(len));
      end else if (pick < 88) begin
        b = 8'($urandom);
        if (b == cur_type) b = ~b;
        push_byte(b);
      end else if (pick < 94) begin
        // truncated header: the next record starts out of step
        push_byte(cur_type);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned min_len;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_byte   <= 8'd0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_RECORD_TYPE;
    cfg_data  <= '0;
    idle_off   = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    cur_type   = RecordTypeRst;
    cur_max    = MaxTotalRst;
    cur_min    = MinTotalRst;
    cur_magic  = MagicRst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: type extremes, length below and above bounds, first record handshake
    push_byte(8'h00);
    push_byte(8'hFF);
    send_header(cur_type, 16'd10);
    send_header(cur_type, 16'hFFFF);
    send_header(cur_type, 16'd11);
    send_payload(11, 1'b1);
    send_header(cur_type, 16'd12);
    send_payload(12, 1'b1);
    settle();

    // upper data bits must be masked off the length register
    write_reg(REG_RECORD_TYPE, 32'h0000_0000);
    write_reg(REG_MAX_TOTAL_LEN, 32'hFFFE_0028);
    write_reg(REG_MIN_TOTAL_LEN, 32'd13);
    write_reg(REG_HANDSHAKE_MAGIC, 32'h0000_0000);
    hold_req = 1'b1;
    random_traffic(400);
    settle();

    write_reg(REG_RECORD_TYPE, 32'h0000_00FF);
    write_reg(REG_MAX_TOTAL_LEN, 32'd20);
    write_reg(REG_MIN_TOTAL_LEN, 32'd20);
    write_reg(REG_HANDSHAKE_MAGIC, 32'hFFFF_FFFF);
    random_traffic(350);
    settle();

    min_len = $urandom_range(13, 24);
    write_reg(REG_RECORD_TYPE, $urandom_range(0, 255));
    write_reg(REG_MIN_TOTAL_LEN, min_len);
    write_reg(REG_MAX_TOTAL_LEN, min_len + $urandom_range(0, 50));
    write_reg(REG_HANDSHAKE_MAGIC, $urandom);
    random_traffic(400);
    settle();

    // max below min: every header fails the length check
    write_reg(REG_MAX_TOTAL_LEN, 32'd5);
    random_traffic(100);
    settle();

    write_reg(REG_RECORD_TYPE, 32'(RecordTypeRst));
    write_reg(REG_HANDSHAKE_MAGIC, MagicRst);
    write_reg(REG_MIN_TOTAL_LEN, 32'd13);
    write_reg(REG_MAX_TOTAL_LEN, 32'd65539);
    send_header(cur_type, 16'hFFFF);
    settle();

    // both bounds at the top: a header one byte short of the floor, without gaps
    write_reg(REG_MAX_TOTAL_LEN, 32'd65540);
    write_reg(REG_MIN_TOTAL_LEN, 32'd65540);
    idle_off = 1'b1;
    send_header(cur_type, 16'hFFFE);
    idle_off = 1'b0;
    settle();

    write_reg(REG_MIN_TOTAL_LEN, 32'd13);
    random_traffic(200);
    settle();
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/rsd_pkg.sv
src/rsd_parser.sv
src/rsd_skid.sv
src/record_stream_deframer.sv
verif/deframe_checker.sv
verif/tb.sv
